FILE: hdl/disc_pair_elastic_collision_assert.svh
// assertion macros for the disc pair collision block
`ifndef DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpc same-cycle check failed");

// next-cycle implication, checked out of reset
`define DPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpc next-cycle check failed");

`endif

FILE: hdl/dpc_pkg.sv
// types, constants and helper functions of the disc pair collision block
`default_nettype none

package dpc_pkg;

  localparam int FRAC_BITS   = 20;
  localparam int NRM_BITS    = 30;
  localparam int CD_W        = 31;
  localparam int LIM_W       = 40;
  localparam int CFG_W       = 40;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int PIPE_DEPTH  = 6 + SQRT_STAGES + 1 + DIV_STAGES + 7;

  localparam logic [CD_W-1:0]  CD_RESET  = CD_W'(64'd20 << FRAC_BITS);
  localparam logic [LIM_W-1:0] LIM_RESET =
    LIM_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000);

  typedef enum logic {
    CFG_CONTACT_DIST = 1'b0,
    CFG_SPEED_LIMIT  = 1'b1
  } cfg_idx_t;

  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_RESOLVED   = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_vx;
    logic signed [31:0] a_vy;
    logic               a_potted;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_vx;
    logic signed [31:0] b_vy;
    logic               b_potted;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_a_x;
    logic signed [31:0] new_a_y;
    logic signed [31:0] new_a_vx;
    logic signed [31:0] new_a_vy;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic signed [31:0] new_b_vx;
    logic signed [31:0] new_b_vy;
    logic [1:0]         contact_status;
  } out_t;

  typedef struct packed {
    in_t         d;
    logic        go;
    logic        zero;
    logic [31:0] aux_a;
    logic [31:0] aux_b;
  } cry_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(~v + 32'sd1) : 32'(v);
  endfunction

  function automatic logic [4:0] lzc31(input logic [30:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i <= 30; i++) begin
      if (v[i]) begin
        n = 5'(30 - i);
      end
    end
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dpc_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module dpc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import dpc_pkg::*;

  logic [63:0] x_r [SQRT_STAGES-1];
  logic [63:0] q_r [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] x_in, q_in, trial, x_nxt, q_nxt;

    if (i == 0) begin : g_first
      assign x_in = rad;
      assign q_in = '0;
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign q_in = q_r[i-1];
    end

    always_comb begin
      trial = q_in + BIT;
      if (x_in >= trial) begin
        x_nxt = x_in - trial;
        q_nxt = (q_in >> 1) + BIT;
      end else begin
        x_nxt = x_in;
        q_nxt = q_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i] <= x_nxt;
        end
      end
    end
  end

  assign root = q_r[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

FILE: hdl/dpc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module dpc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] num,
  input  logic [31:0] den,
  output logic [30:0] quo
);
  import dpc_pkg::*;

  logic [62:0] rem_r [DIV_STAGES-1];
  logic [31:0] den_r [DIV_STAGES-1];
  logic [30:0] q_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - i;
    logic [62:0] rem_in, sub, rem_nxt;
    logic [31:0] den_in;
    logic [30:0] q_in, q_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    always_comb begin
      sub = 63'(den_in) << SH;
      if (rem_in >= sub) begin
        rem_nxt = rem_in - sub;
        q_nxt   = {q_in[29:0], 1'b1};
      end else begin
        rem_nxt = rem_in;
        q_nxt   = {q_in[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/disc_pair_elastic_collision.sv
// top level: equal-mass elastic contact of two discs, fixed point
// throughput: one transaction per cycle; the square root and divider are fully pipelined
// the whole pipeline stalls together while the 2-entry output buffer is full
// reset: synchronous, active low; clears valid bits and buffer, loads register defaults
`default_nettype none
`include "disc_pair_elastic_collision_assert.svh"

module disc_pair_elastic_collision (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dpc_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dpc_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  dpc_pkg::cfg_idx_t         cfg_index,
  input  logic [dpc_pkg::CFG_W-1:0] cfg_wdata
);
  import dpc_pkg::*;

  // configuration
  logic [CD_W-1:0]  cd_r;
  logic [LIM_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r  <= CD_RESET;
      lim_r <= LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTACT_DIST: cd_r  <= cfg_wdata[CD_W-1:0];
        CFG_SPEED_LIMIT:  lim_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  pipe_en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [1:0]            skid_cnt_r;
  logic                  push, pop;

  assign pipe_en  = (skid_cnt_r != 2'd2);
  assign in_ready = pipe_en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // stage 1: capture
  in_t s1_d_r;
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_d_r <= in_data;
    end
  end

  // stage 2: differences and magnitudes
  logic [32:0] dx_nxt, dy_nxt;
  in_t         s2_d_r;
  logic [32:0] s2_mx_r, s2_my_r;
  logic [31:0] s2_vm_r [4];

  assign dx_nxt = {s1_d_r.b_x[31], s1_d_r.b_x} - {s1_d_r.a_x[31], s1_d_r.a_x};
  assign dy_nxt = {s1_d_r.b_y[31], s1_d_r.b_y} - {s1_d_r.a_y[31], s1_d_r.a_y};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_d_r     <= s1_d_r;
      s2_mx_r    <= dx_nxt[32] ? (~dx_nxt + 33'd1) : dx_nxt;
      s2_my_r    <= dy_nxt[32] ? (~dy_nxt + 33'd1) : dy_nxt;
      s2_vm_r[0] <= abs32(s1_d_r.a_vx);
      s2_vm_r[1] <= abs32(s1_d_r.a_vy);
      s2_vm_r[2] <= abs32(s1_d_r.b_vx);
      s2_vm_r[3] <= abs32(s1_d_r.b_vy);
    end
  end

  // stage 3: squares and normalizing shift
  logic [30:0] mx31, my31, mmax;
  in_t         s3_d_r;
  logic        s3_inrng_r;
  logic [61:0] s3_mxx_r, s3_myy_r, s3_cd2_r;
  logic [63:0] s3_vsq_r [4];
  logic [30:0] s3_mx_r, s3_my_r;
  logic [4:0]  s3_k_r;

  assign mx31 = s2_mx_r[30:0];
  assign my31 = s2_my_r[30:0];
  assign mmax = (mx31 >= my31) ? mx31 : my31;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_d_r     <= s2_d_r;
      s3_inrng_r <= (s2_mx_r[32:31] == 2'b00) && (s2_my_r[32:31] == 2'b00);
      s3_mxx_r   <= mx31 * mx31;
      s3_myy_r   <= my31 * my31;
      s3_cd2_r   <= cd_r * cd_r;
      for (int i = 0; i < 4; i++) begin
        s3_vsq_r[i] <= s2_vm_r[i] * s2_vm_r[i];
      end
      s3_mx_r    <= mx31;
      s3_my_r    <= my31;
      s3_k_r     <= lzc31(mmax);
    end
  end

  // stage 4: speed tests, distance test, normalize
  logic [64:0] sqa_nxt, sqb_nxt;
  logic [62:0] d2_nxt;
  in_t         s4_d_r;
  logic        s4_inrng_r, s4_mov_r, s4_near_r;
  logic [62:0] s4_d2_r;
  logic [30:0] s4_sx_r, s4_sy_r;

  assign sqa_nxt = {1'b0, s3_vsq_r[0]} + {1'b0, s3_vsq_r[1]};
  assign sqb_nxt = {1'b0, s3_vsq_r[2]} + {1'b0, s3_vsq_r[3]};
  assign d2_nxt  = {1'b0, s3_mxx_r} + {1'b0, s3_myy_r};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_d_r     <= s3_d_r;
      s4_inrng_r <= s3_inrng_r;
      s4_mov_r   <= (sqa_nxt >= {25'd0, lim_r}) || (sqb_nxt >= {25'd0, lim_r});
      s4_near_r  <= d2_nxt < {1'b0, s3_cd2_r};
      s4_d2_r    <= d2_nxt;
      s4_sx_r    <= s3_mx_r << s3_k_r;
      s4_sy_r    <= s3_my_r << s3_k_r;
    end
  end

  // stage 5: contact decision, scaled squares
  in_t         s5_d_r;
  logic        s5_go_r, s5_zero_r;
  logic [62:0] s5_d2_r;
  logic [61:0] s5_sxx_r, s5_syy_r;
  logic [30:0] s5_sx_r, s5_sy_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s5_d_r    <= s4_d_r;
      s5_go_r   <= !s4_d_r.a_potted && !s4_d_r.b_potted && s4_mov_r
                   && s4_inrng_r && s4_near_r;
      s5_zero_r <= (s4_d2_r == 63'd0);
      s5_d2_r   <= s4_d2_r;
      s5_sxx_r  <= s4_sx_r * s4_sx_r;
      s5_syy_r  <= s4_sy_r * s4_sy_r;
      s5_sx_r   <= s4_sx_r;
      s5_sy_r   <= s4_sy_r;
    end
  end

  // stage 6: scaled length squared
  cry_t        s6_cry_r;
  logic [62:0] s6_d2s_r, s6_d2_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s6_cry_r.d     <= s5_d_r;
      s6_cry_r.go    <= s5_go_r;
      s6_cry_r.zero  <= s5_zero_r;
      s6_cry_r.aux_a <= {1'b0, s5_sx_r};
      s6_cry_r.aux_b <= {1'b0, s5_sy_r};
      s6_d2s_r       <= {1'b0, s5_sxx_r} + {1'b0, s5_syy_r};
      s6_d2_r        <= s5_d2_r;
    end
  end

  // square roots: scaled length and true distance
  logic [31:0] s_root, dist_root;
  cry_t        sq_line_r [SQRT_STAGES];
  cry_t        sq_last;

  dpc_isqrt u_sqrt_len (
    .clk  (clk),
    .en   (pipe_en),
    .rad  ({1'b0, s6_d2s_r}),
    .root (s_root)
  );

  dpc_isqrt u_sqrt_dist (
    .clk  (clk),
    .en   (pipe_en),
    .rad  ({1'b0, s6_d2_r}),
    .root (dist_root)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_line_r[0] <= s6_cry_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sq_line_r[i] <= sq_line_r[i-1];
      end
    end
  end

  assign sq_last = sq_line_r[SQRT_STAGES-1];

  // stage 39: overlap and divider operands
  cry_t        s39_cry_nxt;
  cry_t        s39_cry_r;
  logic [62:0] s39_nnx_r, s39_nny_r;
  logic [31:0] s39_s_r;

  always_comb begin
    s39_cry_nxt       = sq_last;
    s39_cry_nxt.aux_a = {1'b0, cd_r} - dist_root;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s39_cry_r <= s39_cry_nxt;
      s39_nnx_r <= (63'(sq_last.aux_a[30:0]) << NRM_BITS) + 63'(s_root[31:1]);
      s39_nny_r <= (63'(sq_last.aux_b[30:0]) << NRM_BITS) + 63'(s_root[31:1]);
      s39_s_r   <= s_root;
    end
  end

  // unit normal division
  logic [30:0] qx, qy;
  cry_t        div_line_r [DIV_STAGES];
  cry_t        dl;

  dpc_div u_div_x (
    .clk (clk),
    .en  (pipe_en),
    .num (s39_nnx_r),
    .den (s39_s_r),
    .quo (qx)
  );

  dpc_div u_div_y (
    .clk (clk),
    .en  (pipe_en),
    .num (s39_nny_r),
    .den (s39_s_r),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      div_line_r[0] <= s39_cry_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_line_r[i] <= div_line_r[i-1];
      end
    end
  end

  assign dl = div_line_r[DIV_STAGES-1];

  // stage 71: signed normal, relative velocity
  logic               neg_x, neg_y;
  cry_t               s71_cry_r;
  logic signed [31:0] s71_nx_r, s71_ny_r;
  logic [30:0]        s71_nmx_r, s71_nmy_r;
  logic               s71_sgx_r, s71_sgy_r;
  logic signed [32:0] s71_dvx_r, s71_dvy_r;

  assign neg_x = dl.d.b_x < dl.d.a_x;
  assign neg_y = dl.d.b_y < dl.d.a_y;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s71_cry_r <= dl;
      s71_nx_r  <= neg_x ? (32'd0 - {1'b0, qx}) : {1'b0, qx};
      s71_ny_r  <= neg_y ? (32'd0 - {1'b0, qy}) : {1'b0, qy};
      s71_nmx_r <= qx;
      s71_nmy_r <= qy;
      s71_sgx_r <= neg_x;
      s71_sgy_r <= neg_y;
      s71_dvx_r <= {dl.d.a_vx[31], dl.d.a_vx} - {dl.d.b_vx[31], dl.d.b_vx};
      s71_dvy_r <= {dl.d.a_vy[31], dl.d.a_vy} - {dl.d.b_vy[31], dl.d.b_vy};
    end
  end

  // stage 72: push products and projection terms
  cry_t               s72_cry_r;
  logic [62:0]        s72_pox_r, s72_poy_r;
  logic signed [64:0] s72_tx_r, s72_ty_r;
  logic signed [31:0] s72_nx_r, s72_ny_r;
  logic               s72_sgx_r, s72_sgy_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s72_cry_r <= s71_cry_r;
      s72_pox_r <= s71_cry_r.aux_a * s71_nmx_r;
      s72_poy_r <= s71_cry_r.aux_a * s71_nmy_r;
      s72_tx_r  <= s71_dvx_r * s71_nx_r;
      s72_ty_r  <= s71_dvy_r * s71_ny_r;
      s72_nx_r  <= s71_nx_r;
      s72_ny_r  <= s71_ny_r;
      s72_sgx_r <= s71_sgx_r;
      s72_sgy_r <= s71_sgy_r;
    end
  end

  // stage 73: rounded push, dot product
  logic [63:0]        pxr_nxt, pyr_nxt;
  cry_t               s73_cry_r;
  logic signed [32:0] s73_px_r, s73_py_r;
  logic signed [65:0] s73_dot_r;
  logic signed [31:0] s73_nx_r, s73_ny_r;

  assign pxr_nxt = (64'(s72_pox_r) + (64'd1 << NRM_BITS)) >> (NRM_BITS + 1);
  assign pyr_nxt = (64'(s72_poy_r) + (64'd1 << NRM_BITS)) >> (NRM_BITS + 1);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s73_cry_r <= s72_cry_r;
      s73_px_r  <= s72_sgx_r ? (33'd0 - {1'b0, pxr_nxt[31:0]}) : {1'b0, pxr_nxt[31:0]};
      s73_py_r  <= s72_sgy_r ? (33'd0 - {1'b0, pyr_nxt[31:0]}) : {1'b0, pyr_nxt[31:0]};
      s73_dot_r <= {s72_tx_r[64], s72_tx_r} + {s72_ty_r[64], s72_ty_r};
      s73_nx_r  <= s72_nx_r;
      s73_ny_r  <= s72_ny_r;
    end
  end

  // stage 74: rounded projection
  logic [65:0]        dmag_nxt, pm_nxt;
  cry_t               s74_cry_r;
  logic signed [32:0] s74_px_r, s74_py_r;
  logic signed [36:0] s74_p_r;
  logic signed [31:0] s74_nx_r, s74_ny_r;

  assign dmag_nxt = s73_dot_r[65] ? (~s73_dot_r + 66'd1) : s73_dot_r;
  assign pm_nxt   = (dmag_nxt + (66'd1 << (NRM_BITS - 1))) >> NRM_BITS;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s74_cry_r <= s73_cry_r;
      s74_px_r  <= s73_px_r;
      s74_py_r  <= s73_py_r;
      s74_p_r   <= s73_dot_r[65] ? (37'd0 - {1'b0, pm_nxt[35:0]}) : {1'b0, pm_nxt[35:0]};
      s74_nx_r  <= s73_nx_r;
      s74_ny_r  <= s73_ny_r;
    end
  end

  // stage 75: exchange products
  cry_t               s75_cry_r;
  logic signed [32:0] s75_px_r, s75_py_r;
  logic signed [68:0] s75_ex_r, s75_ey_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s75_cry_r <= s74_cry_r;
      s75_px_r  <= s74_px_r;
      s75_py_r  <= s74_py_r;
      s75_ex_r  <= s74_p_r * s74_nx_r;
      s75_ey_r  <= s74_p_r * s74_ny_r;
    end
  end

  // stage 76: rounded exchange
  logic [68:0]        exm_nxt, eym_nxt, exr_nxt, eyr_nxt;
  cry_t               s76_cry_r;
  logic signed [32:0] s76_px_r, s76_py_r;
  logic signed [36:0] s76_ex_r, s76_ey_r;

  assign exm_nxt = s75_ex_r[68] ? (~s75_ex_r + 69'd1) : s75_ex_r;
  assign eym_nxt = s75_ey_r[68] ? (~s75_ey_r + 69'd1) : s75_ey_r;
  assign exr_nxt = (exm_nxt + (69'd1 << (NRM_BITS - 1))) >> NRM_BITS;
  assign eyr_nxt = (eym_nxt + (69'd1 << (NRM_BITS - 1))) >> NRM_BITS;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s76_cry_r <= s75_cry_r;
      s76_px_r  <= s75_px_r;
      s76_py_r  <= s75_py_r;
      s76_ex_r  <= s75_ex_r[68] ? (37'd0 - {1'b0, exr_nxt[35:0]}) : {1'b0, exr_nxt[35:0]};
      s76_ey_r  <= s75_ey_r[68] ? (37'd0 - {1'b0, eyr_nxt[35:0]}) : {1'b0, eyr_nxt[35:0]};
    end
  end

  // stage 77: apply, saturate, select
  in_t  fd;
  out_t res_nxt;
  out_t s77_out_r;

  assign fd = s76_cry_r.d;

  always_comb begin
    res_nxt.new_a_x  = fd.a_x;
    res_nxt.new_a_y  = fd.a_y;
    res_nxt.new_a_vx = fd.a_vx;
    res_nxt.new_a_vy = fd.a_vy;
    res_nxt.new_b_x  = fd.b_x;
    res_nxt.new_b_y  = fd.b_y;
    res_nxt.new_b_vx = fd.b_vx;
    res_nxt.new_b_vy = fd.b_vy;
    res_nxt.contact_status = ST_NONE;
    if (s76_cry_r.go && s76_cry_r.zero) begin
      res_nxt.contact_status = ST_COINCIDENT;
    end else if (s76_cry_r.go) begin
      res_nxt.new_a_x  = sat32(40'(fd.a_x) - 40'(s76_px_r));
      res_nxt.new_a_y  = sat32(40'(fd.a_y) - 40'(s76_py_r));
      res_nxt.new_a_vx = sat32(40'(fd.a_vx) - 40'(s76_ex_r));
      res_nxt.new_a_vy = sat32(40'(fd.a_vy) - 40'(s76_ey_r));
      res_nxt.new_b_x  = sat32(40'(fd.b_x) + 40'(s76_px_r));
      res_nxt.new_b_y  = sat32(40'(fd.b_y) + 40'(s76_py_r));
      res_nxt.new_b_vx = sat32(40'(fd.b_vx) + 40'(s76_ex_r));
      res_nxt.new_b_vy = sat32(40'(fd.b_vy) + 40'(s76_ey_r));
      res_nxt.contact_status = ST_RESOLVED;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s77_out_r <= res_nxt;
    end
  end

  // output skid buffer
  out_t skid0_r, skid1_r;

  assign push      = pipe_en && vld_r[PIPE_DEPTH-1];
  assign pop       = out_valid && out_ready;
  assign out_valid = (skid_cnt_r != 2'd0);
  assign out_data  = skid0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_cnt_r <= 2'd0;
    end else begin
      skid_cnt_r <= 2'(skid_cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_cnt_r == 2'd2) begin
        skid0_r <= skid1_r;
      end
      if (push) begin
        if (skid_cnt_r == 2'd2) begin
          skid1_r <= s77_out_r;
        end else begin
          skid0_r <= s77_out_r;
        end
      end
    end else if (push) begin
      if (skid_cnt_r == 2'd0) begin
        skid0_r <= s77_out_r;
      end else begin
        skid1_r <= s77_out_r;
      end
    end
  end

  // checks
  `DPC_ASSERT_NOW(a_skid_bound, 1'b1, skid_cnt_r != 2'd3)
  `DPC_ASSERT_NEXT(a_fill_stall, push && !pop && skid_cnt_r == 2'd1, !in_ready)
  `DPC_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(vld_r))

endmodule

`default_nettype wire
